>>> rtl/pbra_pkg.sv
// Package for the page bitmap run allocator: shared types, codes and constants.
// No dependencies.
package pbra_pkg;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_SHORT   = 2'd1;
    localparam logic [1:0] STATUS_NOSPACE = 2'd2;

    localparam logic [1:0] CFG_HEAP_BASE  = 2'd0;
    localparam logic [1:0] CFG_PAGE_SHIFT = 2'd1;
    localparam logic [1:0] CFG_WORD_COUNT = 2'd2;

    localparam logic [12:0] COUNT_MAX = 13'd8191;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SCAN_RD,
        ST_SCAN_EVAL,
        ST_MARK_RD,
        ST_MARK_WR,
        ST_FINISH,
        ST_OUT
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;        // capture the request
        logic decode;      // compute page count and free start
        logic scan_rd;     // read map word at scan pointer
        logic scan_eval;   // evaluate the word just read
        logic mark_rd;     // read map word at mark pointer
        logic mark_wr;     // write back the modified word
        logic finish;      // update count, build result
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic zero_pages;
        logic is_free;
        logic free_in_range;
        logic scan_hit;
        logic scan_fail;
        logic mark_done;
    } stat_t;

    // Number of zero bits below the lowest set bit, 64 for an all-zero word.
    function automatic logic [6:0] low_zeros(input logic [63:0] w);
        logic [6:0] n;
        n = 7'd64;
        for (int i = 63; i >= 0; i--)
        begin
            if (w[i])
            begin
                n = 7'(i);
            end
        end
        return n;
    endfunction

endpackage

>>> rtl/page_bitmap_run_allocator_unit.sv
// Page bitmap run allocator, top level: joins controller and datapath.
// Depends on pbra_pkg, pbra_ctrl and pbra_dp.
//
// One item at a time. Each item is an allocate or a free of a run of pages.
// An allocation scans the bitmap a word at a time (memory read, then
// evaluation) from word zero until a fitting run is found or the words in use
// are exhausted, then marks the run a word at a time (memory read, then
// write); a free skips the scan. The bitmap sits in a single-port memory
// with per-word valid flags, so reset needs no clearing pass. The result is
// held until taken; the next item is accepted after that.
module page_bitmap_run_allocator_unit
    import pbra_pkg::*;
#(
    parameter int MAP_WORDS = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        op,
    input  logic [31:0] byte_length,
    input  logic [63:0] free_address,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [63:0] run_address,
    output logic [12:0] used_pages
);

    cmd_t  cmd;
    stat_t stat;

    pbra_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .cmd       (cmd)
    );

    pbra_dp #(.MAP_WORDS(MAP_WORDS)) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .cfg_en       (cfg_write),
        .cfg_sel      (cfg_index),
        .cfg_data     (cfg_data),
        .op           (op),
        .byte_length  (byte_length),
        .free_address (free_address),
        .status       (status),
        .run_address  (run_address),
        .used_pages   (used_pages)
    );

endmodule

>>> rtl/pbra_ctrl.sv
// Controller state machine of the page bitmap run allocator.
// Depends on pbra_pkg.
module pbra_ctrl
    import pbra_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    input  logic  out_stall,
    input  stat_t stat,
    output logic  in_stall,
    output logic  out_valid,
    output cmd_t  cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                if (stat.zero_pages)
                begin
                    state_next = ST_FINISH;
                end
                else if (stat.is_free)
                begin
                    state_next = stat.free_in_range ? ST_MARK_RD : ST_FINISH;
                end
                else
                begin
                    state_next = ST_SCAN_RD;
                end
            end
            ST_SCAN_RD:   state_next = ST_SCAN_EVAL;
            ST_SCAN_EVAL:
            begin
                if (stat.scan_hit)
                begin
                    state_next = ST_MARK_RD;
                end
                else if (stat.scan_fail)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    state_next = ST_SCAN_RD;
                end
            end
            ST_MARK_RD:   state_next = ST_MARK_WR;
            ST_MARK_WR:   state_next = stat.mark_done ? ST_FINISH : ST_MARK_RD;
            ST_FINISH:    state_next = ST_OUT;
            ST_OUT:
            begin
                if (!out_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        in_stall  = 1'b1;
        out_valid = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                cmd.load = in_valid;
            end
            ST_DECODE:    cmd.decode = 1'b1;
            ST_SCAN_RD:   cmd.scan_rd = 1'b1;
            ST_SCAN_EVAL: cmd.scan_eval = 1'b1;
            ST_MARK_RD:   cmd.mark_rd = 1'b1;
            ST_MARK_WR:   cmd.mark_wr = 1'b1;
            ST_FINISH:    cmd.finish = 1'b1;
            ST_OUT:       out_valid = 1'b1;
            default:      in_stall = 1'b1;
        endcase
    end

endmodule

>>> rtl/pbra_dp.sv
// Datapath of the page bitmap run allocator: bitmap memory, scan and mark logic.
// Depends on pbra_pkg.
module pbra_dp
    import pbra_pkg::*;
#(
    parameter int MAP_WORDS = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  cmd_t        cmd,
    output stat_t       stat,
    input  logic        cfg_en,
    input  logic [1:0]  cfg_sel,
    input  logic [63:0] cfg_data,
    input  logic        op,
    input  logic [31:0] byte_length,
    input  logic [63:0] free_address,
    output logic [1:0]  status,
    output logic [63:0] run_address,
    output logic [12:0] used_pages
);

    localparam int AW = $clog2(MAP_WORDS);
    localparam int CW = $clog2(MAP_WORDS + 1);

    logic [63:0] heap_base_reg;
    logic [4:0]  page_shift_reg;
    logic [6:0]  word_count_reg;

    logic [63:0] map_mem [MAP_WORDS];
    logic [MAP_WORDS-1:0] map_valid_reg;
    logic [63:0] rd_data_reg;
    logic        rd_valid_reg;

    logic        op_reg;
    logic [31:0] len_reg;
    logic [63:0] faddr_reg;
    logic [31:0] n_reg;
    logic [CW-1:0] words_reg;
    logic [63:0] start_reg;
    logic [CW+6:0] limit;

    logic [CW-1:0] ptr_reg;      // scan word pointer
    logic [31:0] need_reg;       // pages still needed in a long run
    logic        long_act_reg;   // a long run candidate is open
    logic [CW-1:0] cand_reg;
    logic [CW+6:0] first_reg;
    logic [CW+6:0] mpage_reg;    // current page for marking
    logic [CW+6:0] mend_reg;     // one past last page to mark
    logic        hit_reg;
    logic [12:0] used_reg;
    logic [1:0]  status_reg;
    logic [63:0] addr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heap_base_reg  <= '0;
            page_shift_reg <= 5'd12;
            word_count_reg <= 7'd64;
        end
        else if (cfg_en)
        begin
            case (cfg_sel)
                CFG_HEAP_BASE:  heap_base_reg  <= cfg_data;
                CFG_PAGE_SHIFT: page_shift_reg <= cfg_data[4:0];
                CFG_WORD_COUNT: word_count_reg <= cfg_data[6:0];
                default:        heap_base_reg  <= heap_base_reg;
            endcase
        end
    end

    // Decoded request, valid from the cycle after the item is loaded.
    logic [31:0]   n_dec;
    logic [CW-1:0] words_dec;
    logic [63:0]   start_dec;
    assign n_dec     = len_reg >> page_shift_reg;
    assign words_dec = (32'(word_count_reg) < MAP_WORDS) ? CW'(word_count_reg)
                       : CW'(MAP_WORDS);
    assign start_dec = (faddr_reg - heap_base_reg) >> page_shift_reg;
    assign limit     = (CW+7)'(words_dec) << 6;

    // Map read address for either scan or mark.
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] mk_word;
    assign mk_word = mpage_reg[AW+5:6];
    assign rd_addr = cmd.scan_rd ? ptr_reg[AW-1:0] : mk_word;

    // Words never written read as free.
    logic [63:0] w;
    assign w = rd_valid_reg ? rd_data_reg : 64'd0;

    // Mark word update.
    logic [5:0]  mk_lo;
    logic [6:0]  mk_cnt;
    logic [CW+6:0] rem;
    logic [63:0] mk_mask;
    logic [63:0] mk_word_next;
    assign mk_lo = mpage_reg[5:0];
    assign rem   = mend_reg - mpage_reg;
    always_comb
    begin
        logic [6:0] room;
        room = 7'd64 - {1'b0, mk_lo};
        mk_cnt = (rem < (CW+7)'(room)) ? rem[6:0] : room;
        mk_mask = (mk_cnt == 7'd64) ? '1 : (((64'd1 << mk_cnt) - 64'd1) << mk_lo);
        mk_word_next = op_reg ? (w & ~mk_mask) : (w | mk_mask);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.scan_rd || cmd.mark_rd)
        begin
            rd_data_reg <= map_mem[rd_addr];
        end
        if (cmd.mark_wr)
        begin
            map_mem[mk_word] <= mk_word_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.scan_rd || cmd.mark_rd)
            begin
                rd_valid_reg <= map_valid_reg[rd_addr];
            end
            if (cmd.mark_wr)
            begin
                map_valid_reg[mk_word] <= 1'b1;
            end
        end
    end

    // In-word gap search for 2..64 pages on the current word.
    logic        gap_ok;
    logic [5:0]  gap_pos;
    always_comb
    begin
        logic [63:0] m;
        m = (n_reg >= 32'd64) ? '1 : ((64'd1 << n_reg[5:0]) - 64'd1);
        gap_ok  = 1'b0;
        gap_pos = '0;
        for (int b = 63; b >= 0; b--)
        begin
            if ((32'(b) + n_reg <= 32'd64) && ((w & (m << b)) == 64'd0))
            begin
                gap_ok  = 1'b1;
                gap_pos = 6'(b);
            end
        end
    end

    logic [6:0] lz_inv;
    logic [6:0] lz_w;
    assign lz_inv = low_zeros(~w);
    assign lz_w   = low_zeros(w);

    logic last_word;
    assign last_word = (ptr_reg + 1'b1) >= words_reg;

    logic scan_hit, scan_fail;
    logic [CW+6:0] hit_first;
    always_comb
    begin
        scan_hit  = 1'b0;
        scan_fail = 1'b0;
        hit_first = {1'b0, ptr_reg, 6'd0};
        if (ptr_reg >= words_reg)
        begin
            scan_fail = 1'b1;
        end
        else if (n_reg == 32'd1)
        begin
            if (w != '1)
            begin
                scan_hit  = 1'b1;
                hit_first = {1'b0, ptr_reg, lz_inv[5:0]};
            end
            else
            begin
                scan_fail = last_word;
            end
        end
        else if (n_reg <= 32'd64)
        begin
            if (w == 64'd0)
            begin
                scan_hit = 1'b1;
            end
            else if (w != '1 && gap_ok)
            begin
                scan_hit  = 1'b1;
                hit_first = {1'b0, ptr_reg, gap_pos};
            end
            else
            begin
                scan_fail = last_word;
            end
        end
        else if (!long_act_reg)
        begin
            // Word at ptr is a start candidate when fully free.
            if (w == 64'd0 && n_reg - 32'd64 == 32'd0)
            begin
                scan_hit = 1'b1;
            end
            else
            begin
                scan_fail = last_word;
            end
        end
        else
        begin
            hit_first = {1'b0, cand_reg, 6'd0};
            if (need_reg >= 32'd64)
            begin
                if (w == 64'd0)
                begin
                    scan_hit  = (need_reg == 32'd64);
                    scan_fail = !scan_hit && last_word;
                end
                else
                begin
                    // Model resumes after this word.
                    scan_fail = last_word;
                end
            end
            else if ({25'd0, lz_w} >= need_reg)
            begin
                scan_hit = 1'b1;
            end
            else
            begin
                scan_fail = last_word;
            end
        end
    end

    assign stat.zero_pages    = (n_dec == 32'd0);
    assign stat.is_free       = op_reg;
    assign stat.free_in_range = (start_dec < 64'(limit));
    assign stat.scan_hit      = scan_hit;
    assign stat.scan_fail     = scan_fail;
    assign stat.mark_done     = ((mpage_reg + (CW+7)'(mk_cnt)) >= mend_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg     <= '0;
            long_act_reg <= 1'b0;
            hit_reg      <= 1'b0;
        end
        else
        begin
            if (cmd.decode)
            begin
                long_act_reg <= 1'b0;
                hit_reg      <= 1'b0;
            end
            if (cmd.scan_eval)
            begin
                hit_reg <= scan_hit;
                if (n_reg > 32'd64)
                begin
                    if (!long_act_reg)
                    begin
                        long_act_reg <= (w == 64'd0) && !scan_hit;
                    end
                    else if (!(need_reg >= 32'd64 && w == 64'd0))
                    begin
                        long_act_reg <= 1'b0;
                    end
                end
            end
            if (cmd.finish && !stat.zero_pages)
            begin
                if (op_reg)
                begin
                    used_reg <= ({19'd0, used_reg} <= n_reg) ? 13'd0
                                : used_reg - n_reg[12:0];
                end
                else if (hit_reg)
                begin
                    used_reg <= ((32'(used_reg) + n_reg) > 32'(COUNT_MAX)) ? COUNT_MAX
                                : used_reg + n_reg[12:0];
                end
            end
        end
    end

    // Free path takes its first mark page from the decoded start in the decode
    // state and sets the end of its mark range in the first mark read after it.
    logic free_setup_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_setup_reg <= 1'b0;
        end
        else
        begin
            free_setup_reg <= cmd.decode;
        end
    end

    logic [63:0] fspan;
    assign fspan = 64'(limit) - start_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg    <= op;
            len_reg   <= byte_length;
            faddr_reg <= free_address;
        end
        if (cmd.decode)
        begin
            n_reg     <= n_dec;
            words_reg <= words_dec;
            start_reg <= start_dec;
            ptr_reg   <= '0;
        end
        if (cmd.scan_eval)
        begin
            if (scan_hit)
            begin
                first_reg <= hit_first;
                mpage_reg <= hit_first;
                mend_reg  <= (64'(hit_first) + 64'(n_reg) < 64'(limit))
                             ? (CW+7)'(64'(hit_first) + 64'(n_reg)) : limit;
            end
            else if (n_reg > 32'd64 && !long_act_reg && w == 64'd0)
            begin
                cand_reg <= ptr_reg;
                need_reg <= n_reg - 32'd64;
            end
            else if (n_reg > 32'd64 && long_act_reg && need_reg >= 32'd64 && w == 64'd0)
            begin
                need_reg <= need_reg - 32'd64;
            end
            ptr_reg <= ptr_reg + 1'b1;
        end
        if (cmd.decode && op_reg)
        begin
            mpage_reg <= (CW+7)'(start_dec);
        end
        if (free_setup_reg && op_reg && cmd.mark_rd && stat.free_in_range)
        begin
            mend_reg <= (CW+7)'(start_reg + ((64'(n_reg) < fspan) ? 64'(n_reg) : fspan));
        end
        if (cmd.mark_wr)
        begin
            mpage_reg <= mpage_reg + (CW+7)'(mk_cnt);
        end
        if (cmd.finish)
        begin
            if (stat.zero_pages)
            begin
                status_reg <= STATUS_SHORT;
                addr_reg   <= '0;
            end
            else if (op_reg)
            begin
                status_reg <= STATUS_OK;
                addr_reg   <= '0;
            end
            else if (hit_reg)
            begin
                status_reg <= STATUS_OK;
                addr_reg   <= heap_base_reg + (64'(first_reg) << page_shift_reg);
            end
            else
            begin
                status_reg <= STATUS_NOSPACE;
                addr_reg   <= '0;
            end
        end
    end

    assign status      = status_reg;
    assign run_address = addr_reg;
    assign used_pages  = used_reg;

endmodule

>>> rtl/pbra_checker.sv
// Port-level checker for the page bitmap run allocator, with its bind.
// Depends on pbra_pkg.
module pbra_checker
    import pbra_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [1:0]  status,
    input logic [63:0] run_address
);

    // A request and a result are never both open for acceptance.
    assert property (@(posedge clk) disable iff (!rst_n) out_valid |-> in_stall)
        else $error("input open while result pending");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == STATUS_OK || status == STATUS_SHORT ||
                       status == STATUS_NOSPACE))
        else $error("bad status code");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != STATUS_OK |-> run_address == 64'd0)
        else $error("address on error");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status))
        else $error("result dropped");

endmodule

bind page_bitmap_run_allocator_unit pbra_checker u_pbra_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .run_address (run_address)
);

>>> tb/page_bitmap_run_allocator_unit_tb.sv
// Testbench for page_bitmap_run_allocator_unit: directed and random page-run requests,
// checked against a scoreboard class that keeps its own copy of the page bitmap.
// Depends on pbra_pkg and the RTL of page_bitmap_run_allocator_unit.
module page_bitmap_run_allocator_unit_tb
    import pbra_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAP_WORDS   = 64;
    localparam int CYCLE_LIMIT = 4000000;

    typedef struct {
        logic [1:0]  status;
        logic [63:0] run_address;
        logic [12:0] used_pages;
    } alloc_result_t;

    // The scoreboard holds a private copy of the bitmap, the used-page count and
    // the three registers, and predicts the single result that each request gives.
    class alloc_scoreboard;
        logic [63:0]   page_map [MAP_WORDS];
        logic [12:0]   pages_in_use;
        logic [63:0]   heap_base;
        logic [4:0]    page_shift;
        logic [6:0]    word_count;
        alloc_result_t pending [$];
        int            errors;

        function new();
            foreach (page_map[i])
            begin
                page_map[i] = '0;
            end
            pages_in_use = '0;
            heap_base    = '0;
            page_shift   = 5'd12;
            word_count   = 7'd64;
            errors       = 0;
        endfunction

        function void set_register(logic [1:0] idx, logic [63:0] data);
            case (idx)
                CFG_HEAP_BASE:  heap_base  = data;
                CFG_PAGE_SHIFT: page_shift = data[4:0];
                CFG_WORD_COUNT: word_count = data[6:0];
                default: ;
            endcase
        endfunction

        function int unsigned active_words();
            return (word_count < MAP_WORDS) ? word_count : MAP_WORDS;
        endfunction

        // Number of zero bits below the lowest set bit, 64 for an empty word.
        function int unsigned trailing_free(logic [63:0] w);
            int unsigned k;
            k = 0;
            while (k < 64 && !w[k])
            begin
                k++;
            end
            return k;
        endfunction

        // First-fit search; returns 1 and the first page of the run on a hit.
        function bit search_run(longint unsigned n, output longint unsigned first);
            int unsigned     words;
            int unsigned     e;
            int unsigned     chk;
            longint unsigned needed;
            logic [63:0]     mask;
            words = active_words();
            first = 0;
            if (n == 1)
            begin
                for (e = 0; e < words; e++)
                begin
                    if (page_map[e] != '1)
                    begin
                        first = e * 64 + trailing_free(~page_map[e]);
                        return 1;
                    end
                end
                return 0;
            end
            if (n <= 64)
            begin
                mask = (n == 64) ? '1 : ((64'd1 << n) - 64'd1);
                for (e = 0; e < words; e++)
                begin
                    if (page_map[e] == '0)
                    begin
                        first = e * 64;
                        return 1;
                    end
                    if (page_map[e] == '1)
                    begin
                        continue;
                    end
                    // The gap may end at bit 63.
                    for (int unsigned b = 0; b <= 64 - n; b++)
                    begin
                        if ((page_map[e] & (mask << b)) == '0)
                        begin
                            first = e * 64 + b;
                            return 1;
                        end
                    end
                end
                return 0;
            end
            // Long runs start in an empty word and never look past the words in use.
            for (e = 0; e < words; e++)
            begin
                if (page_map[e] != '0)
                begin
                    continue;
                end
                needed = n - 64;
                chk    = e + 1;
                while (needed >= 64)
                begin
                    if (chk >= words || page_map[chk] != '0)
                    begin
                        break;
                    end
                    chk++;
                    needed -= 64;
                end
                if (needed == 0)
                begin
                    first = e * 64;
                    return 1;
                end
                if (needed < 64 && chk < words && trailing_free(page_map[chk]) >= needed)
                begin
                    first = e * 64;
                    return 1;
                end
                e = chk;
            end
            return 0;
        endfunction

        function void note_request(logic req_op, logic [31:0] len, logic [63:0] faddr);
            alloc_result_t   r;
            longint unsigned n;
            longint unsigned limit;
            longint unsigned first;
            longint unsigned start;
            longint unsigned cnt;
            longint unsigned sum;
            n     = longint'(len) >> page_shift;
            limit = active_words() * 64;
            r.status      = STATUS_OK;
            r.run_address = '0;
            if (n == 0)
            begin
                r.status = STATUS_SHORT;
            end
            else if (req_op == 1'b0)
            begin
                if (search_run(n, first))
                begin
                    for (longint unsigned p = first; p < first + n && p < limit; p++)
                    begin
                        page_map[p >> 6][p[5:0]] = 1'b1;
                    end
                    r.run_address = heap_base + (64'(first) << page_shift);
                    sum = pages_in_use + n;
                    pages_in_use = (sum > COUNT_MAX) ? COUNT_MAX : 13'(sum);
                end
                else
                begin
                    r.status = STATUS_NOSPACE;
                end
            end
            else
            begin
                // Page index taken modulo 2^64; bits beyond the words in use are dropped.
                start = (faddr - heap_base) >> page_shift;
                if (start < limit)
                begin
                    cnt = (n < limit - start) ? n : limit - start;
                    for (longint unsigned p = start; p < start + cnt; p++)
                    begin
                        page_map[p >> 6][p[5:0]] = 1'b0;
                    end
                end
                pages_in_use = (n >= pages_in_use) ? '0 : pages_in_use - 13'(n);
            end
            r.used_pages = pages_in_use;
            pending.push_back(r);
        endfunction

        function void check_result(logic [1:0] st, logic [63:0] addr, logic [12:0] used);
            alloc_result_t e;
            if (pending.size() == 0)
            begin
                $error("result with nothing outstanding: status %0d address %h", st, addr);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (st !== e.status)
            begin
                $error("status: expected %0d, got %0d", e.status, st);
                errors++;
            end
            if (addr !== e.run_address)
            begin
                $error("run_address: expected %h, got %h", e.run_address, addr);
                errors++;
            end
            if (used !== e.used_pages)
            begin
                $error("used_pages: expected %0d, got %0d", e.used_pages, used);
                errors++;
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_write = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [63:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        op = 1'b0;
    logic [31:0] byte_length = '0;
    logic [63:0] free_address = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  status;
    logic [63:0] run_address;
    logic [12:0] used_pages;

    alloc_scoreboard sb = new();

    int          cycles = 0;
    bit          quiet_sink = 1'b0;
    int          stall_left = 0;

    // Runs that are currently allocated, kept so that most frees hit real runs.
    logic [63:0] live_addr [$];
    logic [31:0] live_len [$];

    page_bitmap_run_allocator_unit #(.MAP_WORDS(MAP_WORDS)) dut (.*);

    always #6 clk = ~clk;

    // A cycle counter guards against a hung handshake.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Both monitors share one process: the result of the previous item is
    // checked before a new item is noted, should the two fall on one edge.
    // A granted allocation is remembered here, so that later frees can hit it.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                sb.check_result(status, run_address, used_pages);
            end
            if (in_valid && !in_stall)
            begin
                sb.note_request(op, byte_length, free_address);
                if (op == 1'b0 && sb.pending[$].status == STATUS_OK)
                begin
                    live_addr.push_back(sb.pending[$].run_address);
                    live_len.push_back(byte_length);
                end
            end
        end
    end

    // Mostly short gaps, a few long ones.
    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
        begin
            return 0;
        end
        if (r < 93)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 60);
    endfunction

    // The result side stalls at random, except during quiet stretches.
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_stall  <= 1'b1;
        end
        else if (quiet_sink)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            stall_left <= gap_length();
            out_stall  <= 1'b0;
        end
    end

    task automatic write_register(logic [1:0] idx, logic [63:0] data);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_write <= 1'b0;
        sb.set_register(idx, data);
    endtask

    // Drives one item and returns once the block has taken it. valid stays
    // high into the next item when no gap is drawn.
    task automatic send_request(logic req_op, logic [31:0] len, logic [63:0] faddr,
                                bit allow_gap = 1'b1);
        int gap;
        gap = allow_gap ? gap_length() : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        op           <= req_op;
        byte_length  <= len;
        free_address <= faddr;
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
    endtask

    // Lets every outstanding result come back before the registers change.
    task automatic drain();
        @(posedge clk);
        in_valid <= 1'b0;
        while (sb.pending.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);
    endtask

    task automatic configure(logic [63:0] base, logic [4:0] shift, logic [6:0] words);
        write_register(CFG_HEAP_BASE, base);
        write_register(CFG_PAGE_SHIFT, 64'(shift));
        write_register(CFG_WORD_COUNT, 64'(words));
        live_addr.delete();
        live_len.delete();
    endtask

    // Byte length for a given page count, with random bits below one page.
    function automatic logic [31:0] pages_to_bytes(int unsigned pages);
        logic [63:0] v;
        v = (64'(pages) << sb.page_shift) | (64'($urandom()) & ((64'd1 << sb.page_shift) - 1));
        return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
    endfunction

    // Random part of one phase: mostly allocations and frees of runs that
    // were handed out, with some malformed and noisy requests mixed in.
    task automatic random_phase(int items);
        int          r;
        int          k;
        int unsigned pages;
        for (int i = 0; i < items; i++)
        begin
            if (i % 97 == 0)
            begin
                quiet_sink = ($urandom_range(0, 3) == 0);
            end
            r = $urandom_range(0, 99);
            if (r < 50 || live_len.size() == 0)
            begin
                k = $urandom_range(0, 99);
                pages = (k < 60) ? $urandom_range(1, 4) :
                        (k < 85) ? $urandom_range(5, 64) : $urandom_range(65, 300);
                send_request(1'b0, pages_to_bytes(pages), {$urandom(), $urandom()});
            end
            else if (r < 88)
            begin
                k = $urandom_range(0, live_len.size() - 1);
                send_request(1'b1, live_len[k], live_addr[k]);
                live_addr.delete(k);
                live_len.delete(k);
            end
            else if (r < 94)
            begin
                send_request(1'($urandom_range(0, 1)), $urandom(), {$urandom(), $urandom()});
            end
            else
            begin
                send_request(1'($urandom_range(0, 1)), 32'($urandom_range(0, 1)),
                             {$urandom(), $urandom()});
            end
        end
        drain();
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part with the reset register values.
        quiet_sink = 1'b1;
        send_request(1'b0, 32'd0, '0);                 // shorter than a page
        send_request(1'b1, 32'hFFF, '0);               // zero-page free
        send_request(1'b0, 32'h0000_1000, '0);         // one page at bit 0
        send_request(1'b0, 32'h0000_1FFF, '0, 1'b0);   // one page, low bits ignored
        send_request(1'b0, 32'd62 << 12, '0);          // gap running up to bit 63
        send_request(1'b0, 32'd64 << 12, '0);          // whole word, all-ones mask
        send_request(1'b0, 32'd65 << 12, '0);          // two words, long search
        send_request(1'b0, 32'd200 << 12, '0);
        send_request(1'b0, 32'hFFFF_FFFF, '0);         // far too long: no space
        send_request(1'b1, 32'h0000_1000, 64'h1000);   // punch a hole at page one
        send_request(1'b0, 32'h0000_1000, '0);         // first fit refills it
        send_request(1'b1, 32'h0000_1000, 64'h1000);
        send_request(1'b1, 32'h0000_1000, 64'h1000);   // already free
        send_request(1'b1, 32'd64 << 12, 64'hFFFF_FFFF_FFFF_F000); // outside the region
        send_request(1'b1, 32'd4 << 12, 64'd4095 << 12); // clipped at the last page
        send_request(1'b0, 32'd63 << 12, '0);
        send_request(1'b1, 32'hFFFF_FFFF, '0);         // count drops to zero
        send_request(1'b0, 32'd4096 << 12, '0);        // the whole map
        send_request(1'b0, 32'h0000_1000, '0);         // map full
        send_request(1'b1, 32'd4096 << 12, '0);
        drain();
        quiet_sink = 1'b0;

        // Several register settings, the extremes among them.
        configure('0, 5'd12, 7'd64);
        random_phase(400);
        configure(64'hFFFF_FFFF_FFF0_0000, 5'd21, 7'd1);
        random_phase(300);
        configure({$urandom(), $urandom()}, 5'd0, 7'd127);
        random_phase(300);
        configure({$urandom(), $urandom()}, 5'd31, 7'd0);
        random_phase(150);
        configure({$urandom(), 32'h0}, 5'd16, 7'd2);
        random_phase(300);
        configure(64'h8000_0000_0000_0000, 5'd12, 7'd64);
        random_phase(600);

        while (sb.pending.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (300) @(posedge clk);

        if (sb.errors == 0 && sb.pending.size() == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/pbra_pkg.sv
rtl/pbra_ctrl.sv
rtl/pbra_dp.sv
rtl/page_bitmap_run_allocator_unit.sv
rtl/pbra_checker.sv
tb/page_bitmap_run_allocator_unit_tb.sv
